[src/mfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg
// shared types, constants, sigmoid table and saturation helpers for the
// two-layer perceptron core
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int IN_N     = 2;
    localparam int HID      = 16;
    localparam int OUT_N    = 4;
    localparam int HID_W    = $clog2(HID);
    localparam int K_W      = $clog2(OUT_N);

    localparam int N_W1     = IN_N * HID;
    localparam int N_B1_END = N_W1 + HID;
    localparam int N_W2_END = N_B1_END + HID * OUT_N;
    localparam int N_B2_END = N_W2_END + OUT_N;

    localparam int QW = 24;
    localparam int MW = 25;
    localparam int PW = 2 * MW;
    localparam int AW = 52;
    localparam int TW = 72;
    localparam int SW = 56;

    localparam logic [15:0] LR_RESET = 16'd655;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    localparam logic [5:0] STEP_INFER_LAST = 6'd12;
    localparam logic [5:0] STEP_TRAIN_LAST = 6'd53;

    typedef logic signed [QW-1:0] q_t;
    typedef q_t [OUT_N-1:0] q4_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic [128:0][16:0] sig_tab_t;

    typedef enum logic [1:0] {
        OP_INFER = 2'd0,
        OP_TRAIN = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [4:0] {
        LC_NONE, LC_F0, LC_F1, LC_F2, LC_SIG, LC_DV, LC_DV2, LC_OUT,
        LC_E, LC_E_END, LC_EH, LC_H, LC_H2, LC_Q2, LC_Q1, LC_LO, LC_HI,
        LC_SUM, LC_W2, LC_W1, LC_B1M, LC_B1W
    } lane_op_t;

    typedef enum logic [2:0] {
        MC_NONE, MC_TREE, MC_OD, MC_B2M, MC_B2W
    } merge_op_t;

    typedef enum logic [2:0] {
        WF_NONE, WF_W1A, WF_W1B, WF_B1, WF_W2, WF_B2
    } wfield_t;

    typedef struct packed {
        lane_op_t       op;
        logic [K_W-1:0] k;
    } lane_cmd_t;

    typedef struct packed {
        merge_op_t      op;
        logic [K_W-1:0] k;
    } merge_cmd_t;

    typedef struct packed {
        wfield_t        field;
        logic [K_W-1:0] k;
        q_t             data;
    } wr_cmd_t;

    // shift-subtract quotient, only evaluated while building the table
    function automatic logic [95:0] udiv96(input logic [95:0] num, input logic [95:0] den);
        logic [95:0] q;
        logic [95:0] r;
        q = '0;
        r = '0;
        for (int b = 95; b >= 0; b--)
        begin
            r = {r[94:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t   tab;
        logic [95:0] p;
        logic [95:0] d;
        p = 96'h1_0000_0000;
        for (int m = 0; m <= 128; m++)
        begin
            d      = 96'h1_0000_0000 + p;
            tab[m] = 17'(udiv96(96'h1_0000_0000_0000 + (d >> 1), d));
            p      = (p * 96'd4034748382 + 96'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();
    localparam q_t SIG_LO = -24'sd524288;
    localparam q_t SIG_HI = 24'sd524288;

    function automatic q_t sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sh7fffff;
        else if (v < -64'sd8388608)
            return 24'sh800000;
        else
            return v[QW-1:0];
    endfunction

    function automatic logic [16:0] sig_of(input q_t a);
        logic [7:0] idx;
        idx = 8'd128 - {1'b0, a[18:12]};
        if (a < SIG_LO)
            return 17'd0;
        else if (a >= SIG_HI)
            return ONE_Q16;
        else if (!a[19])
            return SIG_TAB[{1'b0, a[18:12]}];
        else
            return ONE_Q16 - SIG_TAB[idx];
    endfunction

endpackage

[src/mfb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface mfb_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [23:0] feature_0;
    logic signed [23:0] feature_1;
    logic signed [23:0] target_0;
    logic signed [23:0] target_1;
    logic signed [23:0] target_2;
    logic signed [23:0] target_3;
    logic [6:0]         weight_index;
    logic signed [23:0] weight_value;

    modport source (output valid, operation, feature_0, feature_1, target_0, target_1,
                    target_2, target_3, weight_index, weight_value, input ready);
    modport sink (input valid, operation, feature_0, feature_1, target_0, target_1,
                  target_2, target_3, weight_index, weight_value, output ready);
endinterface

interface mfb_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] output_0;
    logic signed [23:0] output_1;
    logic signed [23:0] output_2;
    logic signed [23:0] output_3;

    modport source (output valid, output_0, output_1, output_2, output_3, input ready);
    modport sink (input valid, output_0, output_1, output_2, output_3, output ready);
endinterface

[src/mfb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_lane
// one hidden unit: its weights, activation, delta and update datapath
// around a single shared multiplier
// ----------------------------------------------------------------------------
module mfb_lane import mfb_pkg::*; (
    input  logic        clk,
    input  lane_cmd_t   cmd,
    input  logic        wsel,
    input  wr_cmd_t     wr,
    input  q_t          x0,
    input  q_t          x1,
    input  logic [15:0] lr,
    input  q4_t         od,
    output prod_t       prod
);

    q_t                    w1a_reg;
    q_t                    w1b_reg;
    q_t                    b1_reg;
    q4_t                   w2_reg;
    q_t                    e_reg;
    q_t                    h_reg;
    q_t                    hold_reg;
    logic [16:0]           s_reg;
    logic [14:0]           d_reg;
    prod_t                 prod_reg;
    prod_t                 lo_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [TW-1:0]  tot_reg;
    logic signed [MW-1:0]  ma;
    logic signed [MW-1:0]  mb;
    logic signed [MW-1:0]  s_ext;
    logic signed [MW-1:0]  lr_ext;
    logic [16:0]           one_minus_s;
    q_t                    a_pre;

    assign s_ext       = MW'($signed({1'b0, s_reg}));
    assign lr_ext      = MW'($signed({1'b0, lr}));
    assign one_minus_s = ONE_Q16 - s_reg;
    assign a_pre       = sat24(64'(acc_reg >>> 16));
    assign prod        = prod_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            LC_F0:
            begin
                ma = MW'(x0);
                mb = MW'(w1a_reg);
            end
            LC_F1:
            begin
                ma = MW'(x1);
                mb = MW'(w1b_reg);
            end
            LC_DV:
            begin
                ma = s_ext;
                mb = MW'($signed({1'b0, one_minus_s}));
            end
            LC_OUT:
            begin
                ma = s_ext;
                mb = MW'(w2_reg[cmd.k]);
            end
            LC_E:
            begin
                ma = MW'(od[cmd.k]);
                mb = MW'(w2_reg[cmd.k]);
            end
            LC_H:
            begin
                ma = MW'(e_reg);
                mb = MW'($signed({1'b0, d_reg}));
            end
            LC_Q2:
            begin
                ma = MW'(od[cmd.k]);
                mb = s_ext;
            end
            LC_Q1:
            begin
                ma = MW'(h_reg);
                mb = cmd.k[0] ? MW'(x1) : MW'(x0);
            end
            LC_LO:
            begin
                ma = MW'($signed({1'b0, prod_reg[23:0]}));
                mb = lr_ext;
            end
            LC_HI:
            begin
                ma = MW'(hold_reg);
                mb = lr_ext;
            end
            LC_B1M:
            begin
                ma = MW'(h_reg);
                mb = lr_ext;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (cmd.op)
            LC_F1:   acc_reg <= (AW'(b1_reg) <<< 16) + AW'(prod_reg);
            LC_F2:   acc_reg <= acc_reg + AW'(prod_reg);
            LC_SIG:  s_reg <= sig_of(a_pre);
            LC_DV2:  d_reg <= prod_reg[30:16];
            LC_E:    acc_reg <= (cmd.k == '0) ? '0 : acc_reg + AW'(prod_reg);
            LC_E_END: acc_reg <= acc_reg + AW'(prod_reg);
            LC_EH:   e_reg <= a_pre;
            LC_H2:   h_reg <= sat24(64'(prod_reg >>> 16));
            LC_LO:   hold_reg <= prod_reg[47:24];
            LC_HI:   lo_reg <= prod_reg;
            LC_SUM:  tot_reg <= (TW'(prod_reg) <<< 24) + TW'(lo_reg);
            LC_W2:   w2_reg[cmd.k] <= sat24(64'(w2_reg[cmd.k]) - 64'(tot_reg >>> 32));
            LC_W1:
            begin
                if (cmd.k[0])
                    w1b_reg <= sat24(64'(w1b_reg) - 64'(tot_reg >>> 32));
                else
                    w1a_reg <= sat24(64'(w1a_reg) - 64'(tot_reg >>> 32));
            end
            LC_B1W:  b1_reg <= sat24(64'(b1_reg) - 64'(prod_reg >>> 16));
            default: ;
        endcase
        if (wsel)
        begin
            case (wr.field)
                WF_W1A:  w1a_reg <= wr.data;
                WF_W1B:  w1b_reg <= wr.data;
                WF_B1:   b1_reg <= wr.data;
                WF_W2:   w2_reg[wr.k] <= wr.data;
                default: ;
            endcase
        end
    end

endmodule

[src/mfb_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_merge
// registered sum tree over the lane products, output bias, output deltas
// and output bias update
// ----------------------------------------------------------------------------
module mfb_merge import mfb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  merge_cmd_t  cmd,
    input  wr_cmd_t     wr,
    input  logic [15:0] lr,
    input  q4_t         tgt,
    input  prod_t       prods [HID],
    output q4_t         y,
    output q4_t         od
);

    localparam int GRP = 4;
    localparam int NG  = HID / GRP;

    logic signed [SW-1:0] part_reg [NG];
    logic signed [SW-1:0] part_next [NG];
    logic signed [SW-1:0] tree_sum;
    logic                 s1_valid_reg;
    logic [K_W-1:0]       s1_k_reg;
    q4_t                  b2_reg;
    q4_t                  y_reg;
    q4_t                  od_reg;
    logic signed [40:0]   bprod_reg;

    assign y  = y_reg;
    assign od = od_reg;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = '0;
            for (int i = 0; i < GRP; i++)
                part_next[g] = part_next[g] + SW'(prods[g * GRP + i]);
        end
        tree_sum = SW'(b2_reg[s1_k_reg]) <<< 16;
        for (int g = 0; g < NG; g++)
            tree_sum = tree_sum + part_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_k_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= (cmd.op == MC_TREE);
            s1_k_reg     <= cmd.k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == MC_TREE)
            part_reg <= part_next;
        if (s1_valid_reg)
            y_reg[s1_k_reg] <= sat24(64'(tree_sum >>> 16));
        case (cmd.op)
            MC_OD:
            begin
                for (int k = 0; k < OUT_N; k++)
                    od_reg[k] <= sat24(64'(y_reg[k]) - 64'(tgt[k]));
            end
            MC_B2M:  bprod_reg <= $signed({1'b0, lr}) * od_reg[cmd.k];
            MC_B2W:  b2_reg[cmd.k] <= sat24(64'(b2_reg[cmd.k]) - 64'(bprod_reg >>> 16));
            default: ;
        endcase
        if (wr.field == WF_B2)
            b2_reg[wr.k] <= wr.data;
    end

endmodule

[src/mlp_forward_backprop_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_forward_backprop_core
// two-layer perceptron with sigmoid hidden units: weight load, inference
// and one sgd training step, sixteen hidden-unit lanes and a merge stage
// ----------------------------------------------------------------------------
// an infer or train command gives one result beat once the sequencer program
// ends; write beats give no result
// one command at a time; the core accepts the next command only after it has
// returned to idle at the end of the program, and a finished command waits
// on the result register while the previous result is not yet taken
// reset clears sequencer and result valid, learning rate returns to 655,
// weights are undefined until loaded
module mlp_forward_backprop_core import mfb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mfb_item_if.sink     item,
    mfb_result_if.source result,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    state_t       state_reg, state_next;
    logic [5:0]   step_reg, step_next;
    logic         train_reg, train_next;
    logic         out_valid_reg, out_valid_next;
    logic [15:0]  lr_reg;
    q_t           x0_reg, x1_reg;
    q4_t          t_reg;
    q4_t          out_reg;
    q4_t          y;
    q4_t          od;
    lane_cmd_t    lcmd;
    merge_cmd_t   mcmd;
    wr_cmd_t      wr;
    logic [HID-1:0] wsel;
    logic [HID_W-1:0] wlane;
    prod_t        prods [HID];
    logic         accept;
    logic         last_step;
    logic         load_out;
    logic [6:0]   widx_w2;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.output_0 = out_reg[0];
    assign result.output_1 = out_reg[1];
    assign result.output_2 = out_reg[2];
    assign result.output_3 = out_reg[3];

    assign last_step = (state_reg == ST_RUN) &&
                       ((!train_reg && step_reg == STEP_INFER_LAST) ||
                        step_reg == STEP_TRAIN_LAST);
    assign load_out  = last_step && (!out_valid_reg || result.ready);

    // weight word decode
    assign widx_w2 = item.weight_index - 7'(N_B1_END);
    always_comb
    begin
        wr.field = WF_NONE;
        wr.k     = '0;
        wr.data  = item.weight_value;
        wlane    = '0;
        if (accept && op_t'(item.operation) == OP_WRITE)
        begin
            if (item.weight_index < 7'(N_W1))
            begin
                wr.field = item.weight_index[HID_W] ? WF_W1B : WF_W1A;
                wlane    = item.weight_index[HID_W-1:0];
            end
            else if (item.weight_index < 7'(N_B1_END))
            begin
                wr.field = WF_B1;
                wlane    = item.weight_index[HID_W-1:0];
            end
            else if (item.weight_index < 7'(N_W2_END))
            begin
                wr.field = WF_W2;
                wlane    = widx_w2[K_W+HID_W-1:K_W];
                wr.k     = widx_w2[K_W-1:0];
            end
            else if (item.weight_index < 7'(N_B2_END))
            begin
                wr.field = WF_B2;
                wr.k     = item.weight_index[K_W-1:0];
            end
        end
        for (int j = 0; j < HID; j++)
            wsel[j] = (wlane == HID_W'(j)) && (wr.field != WF_NONE) && (wr.field != WF_B2);
    end

    // sequencer program
    always_comb
    begin
        lcmd = '{LC_NONE, '0};
        mcmd = '{MC_NONE, '0};
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                6'd0:  lcmd = '{LC_F0, 2'd0};
                6'd1:  lcmd = '{LC_F1, 2'd0};
                6'd2:  lcmd = '{LC_F2, 2'd0};
                6'd3:  lcmd = '{LC_SIG, 2'd0};
                6'd4:  lcmd = '{LC_DV, 2'd0};
                6'd5:  lcmd = '{LC_DV2, 2'd0};
                6'd6:  lcmd = '{LC_OUT, 2'd0};
                6'd7:
                begin
                    lcmd = '{LC_OUT, 2'd1};
                    mcmd = '{MC_TREE, 2'd0};
                end
                6'd8:
                begin
                    lcmd = '{LC_OUT, 2'd2};
                    mcmd = '{MC_TREE, 2'd1};
                end
                6'd9:
                begin
                    lcmd = '{LC_OUT, 2'd3};
                    mcmd = '{MC_TREE, 2'd2};
                end
                6'd10: mcmd = '{MC_TREE, 2'd3};
                6'd12: mcmd = '{MC_OD, 2'd0};
                6'd13:
                begin
                    lcmd = '{LC_E, 2'd0};
                    mcmd = '{MC_B2M, 2'd0};
                end
                6'd14:
                begin
                    lcmd = '{LC_E, 2'd1};
                    mcmd = '{MC_B2W, 2'd0};
                end
                6'd15:
                begin
                    lcmd = '{LC_E, 2'd2};
                    mcmd = '{MC_B2M, 2'd1};
                end
                6'd16:
                begin
                    lcmd = '{LC_E, 2'd3};
                    mcmd = '{MC_B2W, 2'd1};
                end
                6'd17:
                begin
                    lcmd = '{LC_E_END, 2'd0};
                    mcmd = '{MC_B2M, 2'd2};
                end
                6'd18:
                begin
                    lcmd = '{LC_EH, 2'd0};
                    mcmd = '{MC_B2W, 2'd2};
                end
                6'd19:
                begin
                    lcmd = '{LC_H, 2'd0};
                    mcmd = '{MC_B2M, 2'd3};
                end
                6'd20:
                begin
                    lcmd = '{LC_H2, 2'd0};
                    mcmd = '{MC_B2W, 2'd3};
                end
                6'd21: lcmd = '{LC_Q2, 2'd0};
                6'd22: lcmd = '{LC_LO, 2'd0};
                6'd23: lcmd = '{LC_HI, 2'd0};
                6'd24: lcmd = '{LC_SUM, 2'd0};
                6'd25: lcmd = '{LC_W2, 2'd0};
                6'd26: lcmd = '{LC_Q2, 2'd1};
                6'd27: lcmd = '{LC_LO, 2'd1};
                6'd28: lcmd = '{LC_HI, 2'd1};
                6'd29: lcmd = '{LC_SUM, 2'd1};
                6'd30: lcmd = '{LC_W2, 2'd1};
                6'd31: lcmd = '{LC_Q2, 2'd2};
                6'd32: lcmd = '{LC_LO, 2'd2};
                6'd33: lcmd = '{LC_HI, 2'd2};
                6'd34: lcmd = '{LC_SUM, 2'd2};
                6'd35: lcmd = '{LC_W2, 2'd2};
                6'd36: lcmd = '{LC_Q2, 2'd3};
                6'd37: lcmd = '{LC_LO, 2'd3};
                6'd38: lcmd = '{LC_HI, 2'd3};
                6'd39: lcmd = '{LC_SUM, 2'd3};
                6'd40: lcmd = '{LC_W2, 2'd3};
                6'd41: lcmd = '{LC_Q1, 2'd0};
                6'd42: lcmd = '{LC_LO, 2'd0};
                6'd43: lcmd = '{LC_HI, 2'd0};
                6'd44: lcmd = '{LC_SUM, 2'd0};
                6'd45: lcmd = '{LC_W1, 2'd0};
                6'd46: lcmd = '{LC_Q1, 2'd1};
                6'd47: lcmd = '{LC_LO, 2'd1};
                6'd48: lcmd = '{LC_HI, 2'd1};
                6'd49: lcmd = '{LC_SUM, 2'd1};
                6'd50: lcmd = '{LC_W1, 2'd1};
                6'd51: lcmd = '{LC_B1M, 2'd0};
                6'd52: lcmd = '{LC_B1W, 2'd0};
                default: ;
            endcase
        end
    end

    // sequencer state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        train_next     = train_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept && (op_t'(item.operation) == OP_INFER ||
                               op_t'(item.operation) == OP_TRAIN))
                begin
                    state_next = ST_RUN;
                    train_next = (op_t'(item.operation) == OP_TRAIN);
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    if (load_out)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                        step_next      = '0;
                    end
                end
                else
                    step_next = step_reg + 6'd1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            train_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            lr_reg        <= LR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            train_reg     <= train_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                lr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg   <= item.feature_0;
            x1_reg   <= item.feature_1;
            t_reg[0] <= item.target_0;
            t_reg[1] <= item.target_1;
            t_reg[2] <= item.target_2;
            t_reg[3] <= item.target_3;
        end
        if (load_out)
            out_reg <= y;
    end

    for (genvar j = 0; j < HID; j++)
    begin : g_lane
        mfb_lane u_lane (
            .clk  (clk),
            .cmd  (lcmd),
            .wsel (wsel[j]),
            .wr   (wr),
            .x0   (x0_reg),
            .x1   (x1_reg),
            .lr   (lr_reg),
            .od   (od),
            .prod (prods[j])
        );
    end

    mfb_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .wr    (wr),
        .lr    (lr_reg),
        .tgt   (t_reg),
        .prods (prods),
        .y     (y),
        .od    (od)
    );

`ifndef SYNTHESIS
    a_ready_at_step0: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> step_reg == 6'd0)
        else $error("ready while sequencer mid-program");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result raised without a finished command");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_TRAIN_LAST)
        else $error("sequencer step out of range");

    a_infer_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !train_reg) |-> step_reg <= STEP_INFER_LAST)
        else $error("infer ran into training steps");
`endif

endmodule
